@@ hw/rtl/yuv2rgb_pkg.sv @@
// shared types, format codes and byte layout decoders for the yuv to rgb converter
package yuv2rgb_pkg;

  // format register codes
  localparam logic [2:0] FMT_YUV444 = 3'd0;
  localparam logic [2:0] FMT_UYVY   = 3'd1;
  localparam logic [2:0] FMT_YUYV   = 3'd2;
  localparam logic [2:0] FMT_YUV411 = 3'd3;
  localparam logic [2:0] FMT_MONO8  = 3'd4;

  // what a byte of a group carries
  typedef enum logic [1:0] {
    ROLE_U,
    ROLE_V,
    ROLE_Y
  } role_kind_t;

  typedef struct packed {
    role_kind_t kind;
    logic [1:0] luma_idx;
  } byte_role_t;

  // one completed group, snapshotted for the pixel emitter
  typedef struct packed {
    logic [3:0][7:0]   luma;
    logic signed [9:0] red_ofs;
    logic signed [9:0] green_ofs;
    logic signed [9:0] blue_ofs;
    logic [1:0]        last_idx;
    logic              eof;
  } group_t;

  // assembler status towards the top level
  typedef struct packed {
    logic complete;
    logic pos_zero;
  } asm_status_t;

  // bytes per group, zero for unused codes
  function automatic logic [2:0] group_len(input logic [2:0] fmt);
    logic [2:0] len;
    unique case (fmt)
      FMT_YUV444: len = 3'd3;
      FMT_UYVY:   len = 3'd4;
      FMT_YUYV:   len = 3'd4;
      FMT_YUV411: len = 3'd6;
      FMT_MONO8:  len = 3'd1;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // index of the last pixel of a group
  function automatic logic [1:0] last_index(input logic [2:0] fmt);
    logic [1:0] idx;
    unique case (fmt) inside
      FMT_UYVY, FMT_YUYV: idx = 2'd1;
      FMT_YUV411:         idx = 2'd3;
      default:            idx = 2'd0;
    endcase
    return idx;
  endfunction

  // role of the byte at a given group position
  function automatic byte_role_t byte_role(input logic [2:0] fmt, input logic [2:0] pos);
    byte_role_t r;
    r = '{kind: ROLE_Y, luma_idx: 2'd0};
    unique case (fmt)
      FMT_YUV444: begin
        unique case (pos)
          3'd0:    r.kind = ROLE_U;
          3'd2:    r.kind = ROLE_V;
          default: r.kind = ROLE_Y;
        endcase
      end
      FMT_UYVY: begin
        unique case (pos)
          3'd0:    r.kind = ROLE_U;
          3'd2:    r.kind = ROLE_V;
          3'd3:    r.luma_idx = 2'd1;
          default: r.kind = ROLE_Y;
        endcase
      end
      FMT_YUYV: begin
        unique case (pos)
          3'd1:    r.kind = ROLE_U;
          3'd2:    r.luma_idx = 2'd1;
          3'd3:    r.kind = ROLE_V;
          default: r.kind = ROLE_Y;
        endcase
      end
      FMT_YUV411: begin
        unique case (pos)
          3'd0:    r.kind = ROLE_U;
          3'd2:    r.luma_idx = 2'd1;
          3'd3:    r.kind = ROLE_V;
          3'd4:    r.luma_idx = 2'd2;
          3'd5:    r.luma_idx = 2'd3;
          default: r.kind = ROLE_Y;
        endcase
      end
      default: r.kind = ROLE_Y;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/yuv2rgb_assembler.sv @@
// byte assembler: group position, held samples and chroma offset products
module yuv2rgb_assembler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           fmt,
  input  logic                 accept,
  input  logic [7:0]           source_byte,
  input  logic                 end_of_frame,
  output yuv2rgb_pkg::asm_status_t status,
  output yuv2rgb_pkg::group_t  group_rec
);

  logic [2:0]       pos_r, pos_nxt;
  logic [7:0]       u_r, v_r;
  logic [3:0][7:0]  luma_r;
  logic [7:0]       u_m, v_m;
  logic [3:0][7:0]  luma_m;
  logic [2:0]       glen;
  logic [2:0]       pos_eff;
  logic             fmt_ok;
  logic             is_mono;
  yuv2rgb_pkg::byte_role_t role;
  logic signed [8:0]  u_s, v_s;
  logic signed [20:0] prod_r, prod_g, prod_b;

  // position decode, an out-of-range position counts as the group start
  assign glen    = yuv2rgb_pkg::group_len(fmt);
  assign fmt_ok  = (glen != 3'd0);
  assign pos_eff = (pos_r >= glen) ? 3'd0 : pos_r;
  assign role    = yuv2rgb_pkg::byte_role(fmt, pos_eff);
  assign is_mono = (fmt == yuv2rgb_pkg::FMT_MONO8);

  assign status.complete = fmt_ok && (pos_eff == (glen - 3'd1));
  assign status.pos_zero = (pos_r == 3'd0);

  // held samples with the arriving byte merged in
  always_comb begin
    u_m    = u_r;
    v_m    = v_r;
    luma_m = luma_r;
    case (role.kind)
      yuv2rgb_pkg::ROLE_U: u_m = source_byte;
      yuv2rgb_pkg::ROLE_V: v_m = source_byte;
      default:             luma_m[role.luma_idx] = source_byte;
    endcase
  end

  // next group position
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (!fmt_ok || status.complete || end_of_frame) begin
        pos_nxt = 3'd0;
      end else begin
        pos_nxt = pos_eff + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // sample stores, no reset
  always_ff @(posedge clk) begin
    if (accept && fmt_ok) begin
      u_r    <= u_m;
      v_r    <= v_m;
      luma_r <= luma_m;
    end
  end

  // chroma less 128, as 9-bit two's complement
  assign u_s = $signed({~u_m[7], ~u_m[7], u_m[6:0]});
  assign v_s = $signed({~v_m[7], ~v_m[7], v_m[6:0]});

  // 10-bit fixed point chroma products, floor shift by bit selection
  assign prod_r = 21'(v_s) * 21'sd1436;
  assign prod_g = 21'(u_s) * 21'sd352 + 21'(v_s) * 21'sd731;
  assign prod_b = 21'(u_s) * 21'sd1814;

  // group record handed on when the byte completes a group
  always_comb begin
    group_rec.luma      = luma_m;
    group_rec.red_ofs   = is_mono ? 10'sd0 : prod_r[19:10];
    group_rec.green_ofs = is_mono ? 10'sd0 : -prod_g[19:10];
    group_rec.blue_ofs  = is_mono ? 10'sd0 : prod_b[19:10];
    group_rec.last_idx  = yuv2rgb_pkg::last_index(fmt);
    group_rec.eof       = end_of_frame;
  end

endmodule

@@ hw/rtl/yuv2rgb_emitter.sv @@
// pixel emitter: one-group buffer, pixel counter, conversion and output register
module yuv2rgb_emitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_load,
  input  yuv2rgb_pkg::group_t group_rec,
  output logic                grp_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                out_group_last,
  output logic                out_frame_last
);

  yuv2rgb_pkg::group_t grp_r;
  logic                grp_valid_r;
  logic [1:0]          k_r;
  logic                out_valid_r;
  logic [7:0]          red_r, green_r, blue_r;
  logic                group_last_r, frame_last_r;
  logic                out_adv, pix_load, grp_release, is_last;
  logic [7:0]          y;
  logic signed [10:0]  sum_r, sum_g, sum_b;

  // clamp a small signed sum to 0..255
  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] c;
    if (x < 11'sd0) begin
      c = 8'd0;
    end else if (x > 11'sd255) begin
      c = 8'd255;
    end else begin
      c = x[7:0];
    end
    return c;
  endfunction

  // handshake on the output register
  assign out_adv     = !out_valid_r || !out_stall;
  assign pix_load    = grp_valid_r && out_adv;
  assign is_last     = (k_r == grp_r.last_idx);
  assign grp_release = pix_load && is_last;
  assign grp_free    = !grp_valid_r || grp_release;

  // group buffer and pixel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else if (grp_load) begin
      grp_valid_r <= 1'b1;
      k_r         <= 2'd0;
    end else if (grp_release) begin
      grp_valid_r <= 1'b0;
    end else if (pix_load) begin
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= group_rec;
    end
  end

  // luma plus precomputed chroma offset
  assign y     = grp_r.luma[k_r];
  assign sum_r = $signed({3'b000, y}) + $signed({grp_r.red_ofs[9], grp_r.red_ofs});
  assign sum_g = $signed({3'b000, y}) + $signed({grp_r.green_ofs[9], grp_r.green_ofs});
  assign sum_b = $signed({3'b000, y}) + $signed({grp_r.blue_ofs[9], grp_r.blue_ofs});

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= grp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      red_r        <= clamp8(sum_r);
      green_r      <= clamp8(sum_g);
      blue_r       <= clamp8(sum_b);
      group_last_r <= is_last;
      frame_last_r <= is_last && grp_r.eof;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_group_last = group_last_r;
  assign out_frame_last = frame_last_r;

endmodule

@@ hw/rtl/yuv_to_rgb_pixel_converter.sv @@
// top level of the streaming yuv to rgb pixel converter
// Takes camera bytes and emits RGB pixels. Bytes are gathered into groups by the
// format register; the byte that completes a group moves the whole group, with
// its chroma products already worked out, into a one-group buffer in the same
// cycle, and the emitter sends its pixels (one, two or four) one per cycle while
// not stalled, through a registered output. A byte that would complete a group
// waits only while the buffer still holds pixels of the previous group; every
// other byte is taken at once, so without output stalls the sustained rate is
// one byte per cycle for every format. The first pixel of a group passes the
// group buffer and then the output register. The format register is written with
// cfg_wr_en and should only change while no transaction is in flight.
module yuv_to_rgb_pixel_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_source_byte,
  input  logic       in_end_of_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_group_last,
  output logic       out_frame_last
);

  logic [2:0]                fmt_r;
  logic                      in_accept;
  logic                      grp_load;
  logic                      grp_free;
  yuv2rgb_pkg::asm_status_t  asm_status;
  yuv2rgb_pkg::group_t       group_rec;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= yuv2rgb_pkg::FMT_YUV444;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  // a completing byte waits for the group buffer
  assign in_stall  = asm_status.complete && !grp_free;
  assign in_accept = in_valid && !in_stall;
  assign grp_load  = in_accept && asm_status.complete;

  yuv2rgb_assembler u_assembler (
    .clk          (clk),
    .rst_n        (rst_n),
    .fmt          (fmt_r),
    .accept       (in_accept),
    .source_byte  (in_source_byte),
    .end_of_frame (in_end_of_frame),
    .status       (asm_status),
    .group_rec    (group_rec)
  );

  yuv2rgb_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .grp_load       (grp_load),
    .group_rec      (group_rec),
    .grp_free       (grp_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_group_last (out_group_last),
    .out_frame_last (out_frame_last)
  );

  // end of frame always realigns grouping
  a_eof_realign: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_end_of_frame |=> asm_status.pos_zero)
    else $error("group position not cleared after end of frame");

  // a loaded group puts a pixel on the output through the output register
  a_group_emits: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |-> ##2 out_valid)
    else $error("loaded group not presented on the output");

  // frame end only on the last pixel of a group
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_group_last)
    else $error("frame_last without group_last");

endmodule

@@ test/tb_yuv_to_rgb_pixel_converter.sv @@
// testbench for the streaming yuv to rgb pixel converter: directed rows, random frames, predictor
module tb_yuv_to_rgb_pixel_converter;
  timeunit 1ns;
  timeprecision 1ps;

  // format codes the block ignores
  localparam logic [2:0] FMT_UNUSED_LO = 3'd5;
  localparam logic [2:0] FMT_UNUSED_HI = 3'd7;

  localparam int DIRECTED_ROWS   = 30;
  localparam int BYTE_TARGET     = 220;
  localparam int CALM_FROM       = 190;
  localparam int PRESSURE_FROM   = 90;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       group_last;
    logic       frame_last;
  } pixel_t;

  // one directed byte; gray is the typed colour when typed is set
  typedef struct packed {
    logic [2:0] fmt;
    logic [7:0] data;
    logic       eof;
    logic       typed;
    logic [7:0] gray;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_source_byte;
  logic       in_end_of_frame;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_group_last;
  logic       out_frame_last;

  // predictor state
  logic [2:0] active_format = yuv2rgb_pkg::FMT_YUV444;
  int         group_pos = 0;
  logic [7:0] chroma_u_held = 8'd0;
  logic [7:0] chroma_v_held = 8'd0;
  logic [7:0] luma_held [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
  pixel_t     fresh_px [4];

  pixel_t     pending_pixels [$];
  pixel_t     head_pixel;
  stim_row_t  directed_rows [DIRECTED_ROWS];

  int error_count    = 0;
  int pixels_checked = 0;
  int bytes_taken    = 0;
  int bytes_ignored  = 0;
  int cfg_writes     = 0;
  int cycle_count    = 0;
  bit calm           = 1'b0;
  bit hold_off_req   = 1'b0;

  yuv_to_rgb_pixel_converter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_source_byte  (in_source_byte),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_group_last  (out_group_last),
    .out_frame_last  (out_frame_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // byte order of one group: U and V chroma, lower-case letters are luma slots a..d
  function automatic string layout_of(input logic [2:0] fmt);
    case (fmt)
      yuv2rgb_pkg::FMT_YUV444: return "UaV";
      yuv2rgb_pkg::FMT_UYVY:   return "UaVb";
      yuv2rgb_pkg::FMT_YUYV:   return "aUbV";
      yuv2rgb_pkg::FMT_YUV411: return "UabVcd";
      yuv2rgb_pkg::FMT_MONO8:  return "a";
      default:                 return "";
    endcase
  endfunction

  function automatic logic [7:0] sat8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  // folds one byte into the group and fills fresh_px when the group completes
  function automatic int predict_byte(input logic [7:0] data, input logic eof);
    string lay;
    int    len, pos, npix, yv, uo, vo, k;
    byte   c;
    lay = layout_of(active_format);
    len = lay.len();
    if (len == 0) begin
      group_pos = 0;
      return 0;
    end
    pos = (group_pos >= len) ? 0 : group_pos;
    c = lay[pos];
    if (c == "U") chroma_u_held = data;
    else if (c == "V") chroma_v_held = data;
    else luma_held[c - "a"] = data;
    if (pos + 1 < len) begin
      group_pos = eof ? 0 : pos + 1;
      return 0;
    end
    group_pos = 0;
    npix = (len == 6) ? 4 : (len == 4) ? 2 : 1;
    uo = int'(chroma_u_held) - 128;
    vo = int'(chroma_v_held) - 128;
    for (k = 0; k < npix; k++) begin
      yv = int'(luma_held[k]);
      if (active_format == yuv2rgb_pkg::FMT_MONO8) begin
        fresh_px[k].red   = yv[7:0];
        fresh_px[k].green = yv[7:0];
        fresh_px[k].blue  = yv[7:0];
      end else begin
        fresh_px[k].red   = sat8(yv + ((vo * 1436) >>> 10));
        fresh_px[k].green = sat8(yv - ((uo * 352 + vo * 731) >>> 10));
        fresh_px[k].blue  = sat8(yv + ((uo * 1814) >>> 10));
      end
      fresh_px[k].group_last = (k == npix - 1);
      fresh_px[k].frame_last = (k == npix - 1) && eof;
    end
    return npix;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one byte, wait for the transaction, record what it should produce
  task automatic push_byte(input logic [7:0] data, input logic eof, input logic typed,
                           input logic [7:0] gray);
    int     n, k;
    pixel_t px;
    in_valid        <= 1'b1;
    in_source_byte  <= data;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_stall);
    n = predict_byte(data, eof);
    for (k = 0; k < n; k++) begin
      px = fresh_px[k];
      if (typed) begin
        px.red   = gray;
        px.green = gray;
        px.blue  = gray;
      end
      pending_pixels = {pending_pixels, px};
    end
    if (active_format < FMT_UNUSED_LO) bytes_taken++;
    else bytes_ignored++;
    // random sender gap
    if (!calm && !hold_off_req && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // format change only once the block has gone quiet
  task automatic set_format(input logic [2:0] f);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_format = f;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // stimulus
  initial begin
    int         i, g, p, groups, len, cut, noise;
    logic [2:0] fmt;
    logic       eof;
    bit         pressure_done;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= yuv2rgb_pkg::FMT_YUV444;
    in_valid        <= 1'b0;
    in_source_byte  <= 8'd0;
    in_end_of_frame <= 1'b0;
    pressure_done = 1'b0;
    directed_rows = '{
      // reset format, neutral chroma, black
      '{yuv2rgb_pkg::FMT_YUV444, 8'd128, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV444, 8'd0,   1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV444, 8'd128, 1'b0, 1'b1, 8'd0},
      // full 4:1:1 group, chroma at both extremes, ends the frame
      '{yuv2rgb_pkg::FMT_YUV411, 8'd0,   1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd255, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd85,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd255, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd170, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd0,   1'b1, 1'b0, 8'd0},
      // partial group cut by end of frame
      '{yuv2rgb_pkg::FMT_YUV411, 8'd7,   1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd9,   1'b1, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_UYVY,   8'd255, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_UYVY,   8'd16,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_UYVY,   8'd0,   1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_UYVY,   8'd235, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUYV,   8'd200, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUYV,   8'd50,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUYV,   8'd100, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUYV,   8'd250, 1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_MONO8,  8'd255, 1'b1, 1'b1, 8'd255},
      // unused code swallows the byte
      '{FMT_UNUSED_HI, 8'd77, 1'b1, 1'b0, 8'd0},
      // format change mid-group, position kept
      '{yuv2rgb_pkg::FMT_YUV411, 8'd60,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd90,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV444, 8'd40,  1'b0, 1'b0, 8'd0},
      // format change with position past the new group length
      '{yuv2rgb_pkg::FMT_YUV411, 8'd10,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd20,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd30,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_YUV411, 8'd40,  1'b0, 1'b0, 8'd0},
      '{yuv2rgb_pkg::FMT_MONO8,  8'd99,  1'b0, 1'b1, 8'd99},
      '{yuv2rgb_pkg::FMT_MONO8,  8'd0,   1'b1, 1'b1, 8'd0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].fmt != active_format) set_format(directed_rows[i].fmt);
      push_byte(directed_rows[i].data, directed_rows[i].eof, directed_rows[i].typed,
                directed_rows[i].gray);
    end

    // random frames, mostly well-formed groups
    while (bytes_taken < BYTE_TARGET) begin
      if ($urandom_range(0, 19) < 18) begin
        fmt = 3'($urandom_range(yuv2rgb_pkg::FMT_YUV444, yuv2rgb_pkg::FMT_MONO8));
      end else begin
        fmt = 3'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI));
      end
      set_format(fmt);
      if (fmt >= FMT_UNUSED_LO) begin
        noise = $urandom_range(1, 4);
        for (p = 0; p < noise; p++) push_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'b0, 8'd0);
        continue;
      end
      groups = $urandom_range(1, 6);
      // one long output hold-off while the sender keeps going
      if (!pressure_done && bytes_taken >= PRESSURE_FROM) begin
        pressure_done = 1'b1;
        hold_off_req  = 1'b1;
        groups        = 6;
      end
      len = layout_of(fmt).len();
      for (g = 0; g < groups; g++) begin
        cut = len;
        if (len > 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, len - 1);
        for (p = 0; p < cut; p++) begin
          eof = 1'b0;
          if (p == cut - 1) begin
            // a cut group either ends the frame or is left open for the next format
            if (cut < len) eof = (g != groups - 1) || ($urandom_range(0, 1) == 1);
            else eof = (g == groups - 1) && ($urandom_range(0, 2) == 0);
          end
          push_byte(pick_byte(), eof, 1'b0, 8'd0);
          calm = (bytes_taken >= CALM_FROM);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d pixels from %0d converted bytes across %0d format writes",
             pixels_checked, bytes_taken, cfg_writes);
    $display("%0d bytes under unused codes, one %0d-cycle output hold-off",
             bytes_ignored, HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver back-pressure
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each pixel transaction with the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing expected: r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
        error_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        check_field("red", head_pixel.red, out_red);
        check_field("green", head_pixel.green, out_green);
        check_field("blue", head_pixel.blue, out_blue);
        check_field("group_last", 8'(head_pixel.group_last), 8'(out_group_last));
        check_field("frame_last", 8'(head_pixel.frame_last), 8'(out_frame_last));
        pixels_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
